// ===== sv/keyed_slot_table_macros.svh =====
// keyed_slot_table_macros.svh
// Assertion macros shared by the checker.
`ifndef KEYED_SLOT_TABLE_MACROS_SVH
`define KEYED_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KST_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("keyed_slot_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KST_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("keyed_slot_table: next-cycle check failed");

`endif

// ===== sv/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Types, constants and codes shared by the keyed slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int MODE_W      = 3;
	localparam int KEY_W       = 64;
	localparam int WORD_W      = 32;
	localparam int POS_W       = 5;

	localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_INCREMENT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_COMPACT   = 3'd4;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_MATCH,
		CELL_WRITE,
		CELL_CLEAR,
		CELL_ADD,
		CELL_SHIFT
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_RESOLVE,
		ST_COMPACT
	} kst_state_t;

	typedef struct packed {
		logic [KEY_W-1:0]         key;
		logic signed [WORD_W-1:0] qty;
		logic [WORD_W-1:0]        price;
	} entry_t;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic [KEY_W-1:0]         key;
		logic signed [WORD_W-1:0] qty;
		logic [WORD_W-1:0]        price;
		logic signed [WORD_W-1:0] inc;
	} cmd_t;

	typedef struct packed {
		cell_op_t                 op;
		logic                     pick_free;
		logic [KEY_W-1:0]         key;
		logic signed [WORD_W-1:0] qty;
		logic [WORD_W-1:0]        price;
		logic signed [WORD_W-1:0] inc;
	} cell_ctrl_t;

	// Carried upward from slot 0: a lower slot already took the pick,
	// a lower slot is empty.
	typedef struct packed {
		logic found;
		logic hole;
	} chain_t;

endpackage

`default_nettype wire

// ===== sv/kst_if.sv =====
// ----------------------------------------------------------------------------
// kst_if
// Command and response channels of the keyed slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kst_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic [63:0]        key;
	logic signed [31:0] quantity;
	logic [31:0]        price_bits;
	logic signed [31:0] increment;

	modport source (output valid, output mode, output key, output quantity,
		output price_bits, output increment, input ready);
	modport sink (input valid, input mode, input key, input quantity,
		input price_bits, input increment, output ready);
endinterface

interface kst_rsp_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [4:0] position;

	modport source (output valid, output status, output position, input ready);
	modport sink (input valid, input status, input position, output ready);
endinterface

`default_nettype wire

// ===== sv/kst_cell.sv =====
// ----------------------------------------------------------------------------
// kst_cell
// One table slot: valid bit, entry, key compare and the neighbor links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kst_cell import kst_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire logic       nb_valid,
	input  wire entry_t     nb_entry,
	input  wire chain_t     chain_in,
	output chain_t          chain_out,
	output logic            valid,
	output entry_t          entry,
	output logic            sel,
	output logic            pending
);

	logic   valid_q;
	logic   hit_q;
	entry_t entry_q;
	logic   cand;
	logic   shift;

	assign cand      = ctrl.pick_free ? !valid_q : hit_q;
	assign sel       = cand && !chain_in.found;
	assign shift     = chain_in.hole || !valid_q;
	assign pending   = valid_q && chain_in.hole;
	assign chain_out = '{found: chain_in.found || cand, hole: shift};
	assign valid     = valid_q;
	assign entry     = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			unique case (ctrl.op)
				CELL_MATCH: begin
					hit_q <= valid_q && (entry_q.key == ctrl.key);
				end
				CELL_WRITE: begin
					if (sel) valid_q <= 1'b1;
				end
				CELL_CLEAR: begin
					if (sel) valid_q <= 1'b0;
				end
				CELL_SHIFT: begin
					if (shift) valid_q <= nb_valid;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_WRITE: begin
				if (sel) entry_q <= '{key: ctrl.key, qty: ctrl.qty, price: ctrl.price};
			end
			CELL_ADD: begin
				if (sel) entry_q.qty <= entry_q.qty + ctrl.inc;
			end
			CELL_SHIFT: begin
				if (shift) entry_q <= nb_entry;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/keyed_slot_table.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_table
// Keyed table of TABLE_DEPTH slots built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command beat: mode, key, quantity, price_bits, increment.
//   rsp returns one beat per command: status (0 ok, 1 fail) and the one-based
//   slot position (0 when none).
//   A command is taken only while the block is idle. Insert, remove, search,
//   increment and unknown modes go through capture, parallel key compare in
//   every cell, then lowest-slot pick through the cell chain with update;
//   the response is registered, and the next command can be taken in the
//   same cycle that it turns valid, never before the last one is done.
//   Compact shifts while any valid slot lies above a hole: on each shift
//   every cell at or above the lowest hole takes its upper neighbor's contents.
//   The response sits in an output register; if rsp stalls, the block holds
//   the finished command's update until the register frees.
//   Reset clears all valid bits at once; the table is empty right after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyed_slot_table import kst_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	kst_cmd_if.sink   cmd,
	kst_rsp_if.source rsp
);

	kst_state_t         state_q, state_d;
	cmd_t               cmd_q;
	cell_ctrl_t         ctrl;
	chain_t             chain [TABLE_DEPTH+1];
	logic               valid_v [TABLE_DEPTH+1];
	entry_t             entry_v [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] sel_v;
	logic [TABLE_DEPTH-1:0] pending_v;
	logic [POS_W-1:0]   pick_pos;
	logic               found;
	logic               out_free;
	logic               rsp_load;
	logic               rsp_status_d;
	logic [POS_W-1:0]   rsp_pos_d;
	logic               rsp_valid_q;
	logic               rsp_status_q;
	logic [POS_W-1:0]   rsp_pos_q;

	assign chain[0]             = '0;
	assign valid_v[TABLE_DEPTH] = 1'b0;
	assign entry_v[TABLE_DEPTH] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		kst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.nb_valid  (valid_v[i+1]),
			.nb_entry  (entry_v[i+1]),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.valid     (valid_v[i]),
			.entry     (entry_v[i]),
			.sel       (sel_v[i]),
			.pending   (pending_v[i])
		);
	end

	assign found = chain[TABLE_DEPTH].found;

	always_comb begin
		pick_pos = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (sel_v[i]) pick_pos = pick_pos | POS_W'(i + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= '{mode: cmd.mode, key: cmd.key, qty: cmd.quantity,
				price: cmd.price_bits, inc: cmd.increment};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d        = state_q;
		ctrl.op        = CELL_HOLD;
		ctrl.pick_free = (cmd_q.mode == MODE_INSERT);
		ctrl.key       = cmd_q.key;
		ctrl.qty       = cmd_q.qty;
		ctrl.price     = cmd_q.price;
		ctrl.inc       = cmd_q.inc;
		cmd.ready      = 1'b0;
		rsp_load       = 1'b0;
		rsp_status_d   = 1'b1;
		rsp_pos_d      = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) state_d = ST_MATCH;
			end
			ST_MATCH: begin
				ctrl.op = CELL_MATCH;
				state_d = (cmd_q.mode == MODE_COMPACT) ? ST_COMPACT : ST_RESOLVE;
			end
			ST_RESOLVE: begin
				if (out_free) begin
					rsp_load     = 1'b1;
					state_d      = ST_IDLE;
					rsp_status_d = !found;
					rsp_pos_d    = pick_pos;
					unique case (cmd_q.mode)
						MODE_INSERT:    ctrl.op = CELL_WRITE;
						MODE_REMOVE:    ctrl.op = CELL_CLEAR;
						MODE_SEARCH:    ctrl.op = CELL_HOLD;
						MODE_INCREMENT: ctrl.op = CELL_ADD;
						default: begin
							rsp_status_d = 1'b1;
							rsp_pos_d    = '0;
						end
					endcase
				end
			end
			ST_COMPACT: begin
				if (|pending_v) begin
					ctrl.op = CELL_SHIFT;
				end else if (out_free) begin
					rsp_load     = 1'b1;
					rsp_status_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= rsp_status_d;
			rsp_pos_q    <= rsp_pos_d;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.position = rsp_pos_q;

endmodule

`default_nettype wire

// ===== sv/kst_checker.sv =====
// ----------------------------------------------------------------------------
// kst_sva
// Port-level checks on the keyed slot table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_slot_table_macros.svh"

module kst_sva (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cmd_valid,
	input wire logic       cmd_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic       rsp_status,
	input wire logic [4:0] rsp_position
);

	`KST_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`KST_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_position))
	`KST_ASSERT_NOW(a_fail_no_pos, clk, arst_n, rsp_valid && rsp_status, rsp_position == 5'd0)
	`KST_ASSERT_NEXT(a_busy_after_cmd, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)

endmodule

bind keyed_slot_table kst_sva u_kst_sva (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_position (rsp.position)
);

`default_nettype wire
